### rtl/core/dtrm_pkg.sv
// Package with the shared types, constants and tile span function of the dirty tile marker.
`timescale 1ns / 1ps
package dtrm_pkg;

  localparam int TILE_SHIFT      = 4;
  localparam int MAP_MAX_COLS    = 25;
  localparam int MAP_MAX_ROWS    = 15;
  localparam int DEF_SCREEN_COLS = 400;
  localparam int DEF_SCREEN_ROWS = 240;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int ROW_IDX_W  = 4;
  localparam int SPAN_W     = 5;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_MARK  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic              hit;
    logic [SPAN_W-1:0] lo;
    logic [SPAN_W-1:0] hi;
  } span_t;

  // Floors the start and ceils the end to tiles, then clamps to [0, lim).
  function automatic span_t axis_span(input logic signed [15:0] start,
                                      input logic [15:0] len,
                                      input logic [SPAN_W-1:0] lim);
    logic signed [17:0] end_px;
    logic signed [17:0] end_up;
    logic signed [11:0] a;
    logic signed [13:0] b;
    logic signed [11:0] lim_a;
    logic signed [13:0] lim_b;
    span_t              s;
    end_px = {{2{start[15]}}, start} + $signed({2'b00, len});
    end_up = end_px + 18'sd15;
    a      = 12'(start >>> TILE_SHIFT);
    b      = 14'(end_up >>> TILE_SHIFT);
    lim_a  = $signed({7'd0, lim});
    lim_b  = $signed({9'd0, lim});
    s.hit  = (a < lim_a) && (b > 14'sd0);
    s.lo   = a[11] ? '0 : a[SPAN_W-1:0];
    s.hi   = (b > lim_b) ? lim : b[SPAN_W-1:0];
    return s;
  endfunction

endpackage

### rtl/core/dirty_tile_rectangle_marker_top.sv
// Dirty tile map: clears, marks rectangles by tile and reads back one tile row per word.
//
//   channel | direction | tdata fields (low bit up)                          | tuser
//   in_     | input     | left_x, top_y, rect_width, rect_height, read_row   | action
//   out_    | output    | touched_screen, row_bits                           | none
//
// Each word passes an input register, then the span, mask and map update logic feeding
// the result register. One word per cycle while a stalled result does not hold the pipeline.
// rst_n clears the tile map and both valid flags.
// A stalled result holds the pipeline; in_tready falls only when both stages are full
// and out_tready is low.
`timescale 1ns / 1ps
module dirty_tile_rectangle_marker_top
  import dtrm_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // left_x[15:0], top_y[31:16], rect_width[47:32], rect_height[63:48], read_row[67:64]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // touched_screen[0], row_bits[25:1]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int TILE_COLS = (SCREEN_COLUMNS / 16 < MAP_MAX_COLS) ?
                             SCREEN_COLUMNS / 16 : MAP_MAX_COLS;
  localparam int TILE_ROWS = (SCREEN_ROWS / 16 < MAP_MAX_ROWS) ?
                             SCREEN_ROWS / 16 : MAP_MAX_ROWS;
  localparam logic [SPAN_W-1:0] COLS_LIM = SPAN_W'(TILE_COLS);
  localparam logic [SPAN_W-1:0] ROWS_LIM = SPAN_W'(TILE_ROWS);

  logic                   s1_valid_r;
  action_t                s1_action_r;
  logic signed [15:0]     s1_x_r;
  logic signed [15:0]     s1_y_r;
  logic [15:0]            s1_w_r;
  logic [15:0]            s1_h_r;
  logic [ROW_IDX_W-1:0]   s1_row_r;
  logic                   s1_fire;

  logic                   out_valid_r;
  logic                   out_touched_r;
  logic                   out_touched_nxt;
  logic [MAP_MAX_COLS-1:0] out_bits_r;
  logic [MAP_MAX_COLS-1:0] out_bits_nxt;
  logic                   out_free;

  logic [MAP_MAX_COLS-1:0] map_r   [MAP_MAX_ROWS];
  logic [MAP_MAX_COLS-1:0] map_nxt [MAP_MAX_ROWS];

  span_t                   xs;
  span_t                   ys;
  logic                    hit;
  logic [MAP_MAX_COLS-1:0] col_mask;
  logic [MAP_MAX_ROWS-1:0] row_sel;
  logic [MAP_MAX_COLS-1:0] map_or;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_action_r <= action_t'(in_tuser);
      s1_x_r      <= $signed(in_tdata[15:0]);
      s1_y_r      <= $signed(in_tdata[31:16]);
      s1_w_r      <= in_tdata[47:32];
      s1_h_r      <= in_tdata[63:48];
      s1_row_r    <= in_tdata[67:64];
    end
  end

  always_comb begin
    xs  = axis_span(s1_x_r, s1_w_r, COLS_LIM);
    ys  = axis_span(s1_y_r, s1_h_r, ROWS_LIM);
    hit = xs.hit && ys.hit;
    for (int c = 0; c < MAP_MAX_COLS; c++) begin
      col_mask[c] = (SPAN_W'(c) >= xs.lo) && (SPAN_W'(c) < xs.hi);
    end
    for (int r = 0; r < MAP_MAX_ROWS; r++) begin
      row_sel[r] = (SPAN_W'(r) >= ys.lo) && (SPAN_W'(r) < ys.hi);
    end
  end

  always_comb begin
    out_touched_nxt = 1'b0;
    out_bits_nxt    = '0;
    for (int r = 0; r < MAP_MAX_ROWS; r++) begin
      map_nxt[r] = map_r[r];
    end
    case (s1_action_r)
      ACT_CLEAR: begin
        for (int r = 0; r < MAP_MAX_ROWS; r++) begin
          map_nxt[r] = '0;
        end
      end
      ACT_MARK: begin
        out_touched_nxt = hit;
        for (int r = 0; r < MAP_MAX_ROWS; r++) begin
          if (hit && row_sel[r]) begin
            map_nxt[r] = map_r[r] | col_mask;
          end
        end
      end
      ACT_READ: begin
        if ({1'b0, s1_row_r} < ROWS_LIM) begin
          out_bits_nxt = map_r[s1_row_r];
        end
      end
      default: begin
        out_touched_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAP_MAX_ROWS; r++) begin
        map_r[r] <= '0;
      end
    end else if (s1_fire) begin
      for (int r = 0; r < MAP_MAX_ROWS; r++) begin
        map_r[r] <= map_nxt[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_touched_r <= out_touched_nxt;
      out_bits_r    <= out_bits_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - MAP_MAX_COLS - 1)'(0), out_bits_r, out_touched_r};

  always_comb begin
    map_or = '0;
    for (int r = 0; r < MAP_MAX_ROWS; r++) begin
      map_or = map_or | map_r[r];
    end
  end

  a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_action_r == ACT_CLEAR |=> map_or == '0)
    else $error("tile map not empty after a clear");

  a_touch_mark_only : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_action_r != ACT_MARK |=> !out_touched_r)
    else $error("touched_screen set for a word that is not a mark");

  a_bits_read_only : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_action_r != ACT_READ |=> out_bits_r == '0)
    else $error("row_bits set for a word that is not a read");

  a_cols_in_screen : assert property (@(posedge clk) disable iff (!rst_n)
    (map_or >> TILE_COLS) == '0)
    else $error("tile marked beyond the last screen column");

  a_ready_when_free : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while the result register is empty");

endmodule
